// ----- rtl/chip8_instruction_core_top_macros.svh -----
// Assertion macros for the CHIP-8 instruction core.
// Used by the top level; no other dependencies.
`ifndef CHIP8_INSTRUCTION_CORE_TOP_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_TOP_MACROS_SVH
`define C8_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define C8_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/c8_pkg.sv -----
// Shared types and constants of the CHIP-8 instruction core.
// No dependencies.
package c8_pkg;
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_EXEC  = 2'd1;
   localparam logic [1:0] KIND_ROW   = 2'd2;
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_NEST    = 3'd2;
   localparam logic [2:0] ST_UNSUP   = 3'd3;
   localparam logic [2:0] ST_ACCESS  = 3'd4;
   localparam logic CSR_START = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;
   localparam logic [11:0] RESET_START = 12'h200;
   localparam logic [4:0]  RESET_LIMIT = 5'd12;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] instruction;
      logic [11:0] pc;
      logic [15:0] index_value;
      logic [7:0]  flag_value;
      logic [63:0] row_bits;
   } rsp_type;
endpackage

// ----- rtl/chip8_instruction_core_top.sv -----
// CHIP-8 instruction core: sequencer around byte memory and display memory.
// Throughput: one item in flight; the next is taken at the edge its result leaves.
// Reset: a clearing pass zeroes memory and display (one byte and one row a cycle);
// no item is accepted meanwhile. Uses c8_pkg, c8_memory, c8_screen.
`include "chip8_instruction_core_top_macros.svh"
module chip8_instruction_core_top import c8_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_byte,
   input  logic [4:0]  req_row,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_instruction,
   output logic [11:0] rsp_pc,
   output logic [15:0] rsp_index_value,
   output logic [7:0]  rsp_flag_value,
   output logic [63:0] rsp_row_bits,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [11:0] csr_data
);
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [4:0] SDEPTH = 5'(STACK_DEPTH);

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_F0 = 4'd2, S_F1 = 4'd3,
      S_F2 = 4'd4, S_EX = 4'd5, S_RWAIT = 4'd6, S_ROW = 4'd7, S_DRD = 4'd8,
      S_DWR = 4'd9, S_CLS = 4'd10, S_LDM = 4'd11, S_STM = 4'd12, S_OUT = 4'd13,
      S_DMW = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [11:0] pc_ff, pc_in;
   logic [11:0] start_ff, start_in;
   logic [4:0]  limit_ff, limit_in;
   logic [15:0] i_ff, i_in;
   logic [4:0]  sp_ff, sp_in;
   logic [7:0]  v_ff [16];
   logic [7:0]  v_in [16];
   logic [15:0] ins_ff, ins_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [4:0]  row_ff, row_in;
   logic [5:0]  dcol_ff, dcol_in;
   logic [4:0]  dtop_ff, dtop_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;
   logic [11:0] stk_ff [STACK_DEPTH];
   logic        stk_we;
   logic [SW-1:0] stk_wa;
   logic [11:0] stk_wd;

   logic        m_we, s_we;
   logic [11:0] m_wa, m_ra;
   logic [7:0]  m_wd, m_rd;
   logic [4:0]  s_wa, s_ra;
   logic [63:0] s_wd, s_rd;

   c8_memory u_mem (.clock, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra),
      .rdata(m_rd));
   c8_screen u_scr (.clock, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra),
      .rdata(s_rd));

   logic [3:0]  op, x, y, n;
   logic [7:0]  nn, vx, vy;
   logic [11:0] nnn, nxt, skp;
   logic [8:0]  sum;
   logic [4:0]  lim;
   logic [63:0] sbits;
   logic [5:0]  drow;
   logic        busy_out;

   assign op  = ins_ff[15:12];
   assign x   = ins_ff[11:8];
   assign y   = ins_ff[7:4];
   assign n   = ins_ff[3:0];
   assign nn  = ins_ff[7:0];
   assign nnn = ins_ff[11:0];
   assign vx  = v_ff[x];
   assign vy  = v_ff[y];
   assign nxt = pc_ff + 12'd2;
   assign skp = pc_ff + 12'd4;
   assign sum = {1'b0, vx} + {1'b0, vy};
   assign lim = (limit_ff > SDEPTH) ? SDEPTH : limit_ff;
   assign sbits = {m_rd, 56'd0} >> dcol_ff;
   assign drow = {1'b0, dtop_ff} + {2'b0, cnt_ff[3:0]};
   assign busy_out = rv_ff && rsp_stall;

   assign req_stall = (state_ff != S_IDLE) || busy_out;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; pc_in = pc_ff; start_in = start_ff;
      limit_in = limit_ff; i_in = i_ff; sp_in = sp_ff; ins_in = ins_ff;
      rnd_in = rnd_ff; row_in = row_ff; rv_in = rv_ff; rsp_in = rsp_ff;
      dcol_in = dcol_ff; dtop_in = dtop_ff;
      for (int k = 0; k < 16; k++) v_in[k] = v_ff[k];
      m_we = 1'b0; m_wa = 12'd0; m_wd = 8'd0; m_ra = pc_ff;
      s_we = 1'b0; s_wa = 5'd0; s_wd = 64'd0; s_ra = row_ff;
      stk_we = 1'b0; stk_wa = sp_ff[SW-1:0]; stk_wd = nxt;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (csr_write) begin
         if (csr_index == CSR_START) begin
            start_in = csr_data; pc_in = csr_data;
         end else begin
            limit_in = csr_data[4:0];
         end
      end
      unique case (state_ff)
         S_CLR: begin
            m_we = 1'b1; m_wa = cnt_ff;
            s_we = 1'b1; s_wa = cnt_ff[4:0];
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff == 12'hFFF) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !busy_out) begin
               rnd_in = req_random_byte; row_in = req_row;
               rsp_in = '0; rsp_in.status = ST_ACCESS;
               if (req_kind == KIND_WRITE) begin
                  m_we = 1'b1; m_wa = req_address; m_wd = req_write_byte;
                  state_in = S_OUT;
               end else if (req_kind == KIND_EXEC) begin
                  m_ra = pc_ff; state_in = S_F0;
               end else if (req_kind == KIND_ROW) begin
                  s_ra = req_row; state_in = S_RWAIT;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_RWAIT: begin
            rsp_in.row_bits = s_rd; state_in = S_OUT;
         end
         S_F0: begin
            ins_in[15:8] = m_rd; m_ra = pc_ff + 12'd1; state_in = S_F1;
         end
         S_F1: begin
            ins_in[7:0] = m_rd; state_in = S_EX;
         end
         S_EX: begin
            rsp_in.instruction = ins_ff; rsp_in.status = ST_OK;
            state_in = S_OUT; cnt_in = 12'd0;
            unique case (op)
               4'h0: begin
                  if (nnn == 12'h0E0) begin
                     pc_in = nxt; state_in = S_CLS;
                  end else if (nnn == 12'h0EE) begin
                     if (sp_ff == 5'd0) rsp_in.status = ST_EMPTY;
                     else begin
                        sp_in = sp_ff - 5'd1;
                        pc_in = stk_ff[SW'(sp_ff - 5'd1)];
                     end
                  end else rsp_in.status = ST_UNSUP;
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  if (sp_ff >= lim) rsp_in.status = ST_NEST;
                  else begin
                     stk_we = 1'b1; sp_in = sp_ff + 5'd1; pc_in = nnn;
                  end
               end
               4'h3: pc_in = (vx == nn) ? skp : nxt;
               4'h4: pc_in = (vx != nn) ? skp : nxt;
               4'h5: pc_in = (vx == vy) ? skp : nxt;
               4'h6: begin v_in[x] = nn; pc_in = nxt; end
               4'h7: begin v_in[x] = vx + nn; pc_in = nxt; end
               4'h8: begin
                  pc_in = nxt;
                  case (n)
                     4'h0: v_in[x] = vy;
                     4'h1: v_in[x] = vx | vy;
                     4'h2: v_in[x] = vx & vy;
                     4'h3: v_in[x] = vx ^ vy;
                     4'h4: begin v_in[15] = {7'd0, sum[8]}; v_in[x] = sum[7:0]; end
                     4'h5: begin v_in[15] = {7'd0, vx >= vy}; v_in[x] = vx - vy; end
                     4'h6: begin v_in[15] = {7'd0, vx[0]}; v_in[x] = vx >> 1; end
                     4'h7: begin v_in[15] = {7'd0, vy >= vx}; v_in[x] = vy - vx; end
                     4'hE: begin v_in[15] = {7'd0, vx[7]}; v_in[x] = vx << 1; end
                     default: ;
                  endcase
               end
               4'h9: pc_in = (vx != vy) ? skp : nxt;
               4'hA: begin i_in = {4'd0, nnn}; pc_in = nxt; end
               4'hB: pc_in = nnn + {4'd0, v_ff[0]};
               4'hC: begin v_in[x] = rnd_ff & nn; pc_in = nxt; end
               4'hD: begin
                  v_in[15] = 8'd0; pc_in = nxt;
                  dcol_in = vx[5:0]; dtop_in = vy[4:0];
                  state_in = (n == 4'd0) ? S_OUT : S_DRD;
               end
               4'hE: rsp_in.status = ST_UNSUP;
               default: begin
                  if (nn == 8'h1E) begin i_in = i_ff + {8'd0, vx}; pc_in = nxt; end
                  else if (nn == 8'h55) begin pc_in = nxt; state_in = S_STM; end
                  else if (nn == 8'h65) begin
                     pc_in = nxt; m_ra = i_ff[11:0]; state_in = S_LDM;
                  end else rsp_in.status = ST_UNSUP;
               end
            endcase
         end
         S_DRD: begin
            if (drow[5] || cnt_ff[3:0] == n) state_in = S_OUT;
            else begin
               m_ra = i_ff[11:0] + cnt_ff; s_ra = drow[4:0]; state_in = S_DWR;
            end
         end
         S_DWR: begin
            m_ra = i_ff[11:0] + cnt_ff; s_ra = drow[4:0]; state_in = S_DMW;
         end
         S_DMW: begin
            s_we = 1'b1; s_wa = drow[4:0]; s_wd = s_rd ^ sbits;
            if ((s_rd & sbits) != 64'd0) v_in[15] = 8'd1;
            cnt_in = cnt_ff + 12'd1; state_in = S_DRD;
         end
         S_CLS: begin
            s_we = 1'b1; s_wa = cnt_ff[4:0]; cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[4:0] == 5'd31) state_in = S_OUT;
         end
         S_STM: begin
            m_we = 1'b1; m_wa = i_ff[11:0] + cnt_ff; m_wd = v_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 12'd1;
            if (cnt_ff[3:0] == x) state_in = S_OUT;
         end
         S_LDM: begin
            if (cnt_ff[4]) begin
               v_in[cnt_ff[3:0]] = m_rd;
               if (cnt_ff[3:0] == x) state_in = S_OUT;
               else begin
                  m_ra = i_ff[11:0] + {8'd0, cnt_ff[3:0]} + 12'd1;
                  cnt_in = {7'd0, 1'b0, cnt_ff[3:0] + 4'd1};
               end
            end else begin
               m_ra = i_ff[11:0] + {8'd0, cnt_ff[3:0]};
               cnt_in = {7'd0, 1'b1, cnt_ff[3:0]};
            end
         end
         S_OUT: begin
            rsp_in.pc = pc_in; rsp_in.index_value = i_in;
            rsp_in.flag_value = v_in[15];
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; cnt_ff <= '0; pc_ff <= RESET_START;
         start_ff <= RESET_START; limit_ff <= RESET_LIMIT; i_ff <= '0;
         sp_ff <= '0; rv_ff <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; pc_ff <= pc_in;
         start_ff <= start_in; limit_ff <= limit_in; i_ff <= i_in;
         sp_ff <= sp_in; rv_ff <= rv_in;
         for (int k = 0; k < 16; k++) v_ff[k] <= v_in[k];
      end
      ins_ff <= ins_in; rnd_ff <= rnd_in; row_ff <= row_in; rsp_ff <= rsp_in;
      dcol_ff <= dcol_in; dtop_ff <= dtop_in;
      if (stk_we) stk_ff[stk_wa] <= stk_wd;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_instruction = rsp_ff.instruction;
   assign rsp_pc          = rsp_ff.pc;
   assign rsp_index_value = rsp_ff.index_value;
   assign rsp_flag_value  = rsp_ff.flag_value;
   assign rsp_row_bits    = rsp_ff.row_bits;

   `C8_ASSERT_IMPL(a_sp_bound, clock, reset, sp_ff <= SDEPTH, "stack level overflow")
   `C8_ASSERT_IMPL(a_no_take_busy, clock, reset, (state_ff != S_IDLE) |-> req_stall, "take while busy")
   `C8_ASSERT_IMPL(a_out_one, clock, reset, (state_ff == S_OUT) |=> rv_ff, "result lost")
   `C8_ASSERT_RST(a_rst_clr, clock, $past(reset) |-> (state_ff == S_CLR), "no clear after reset")
endmodule

// ----- rtl/c8_screen.sv -----
// Display memory of the CHIP-8 core: 32 rows of 64 pixels, one row write port and one registered row read port.
// Uses c8_pkg.
module c8_screen import c8_pkg::*; (
   input  logic        clock,
   input  logic        we,
   input  logic [4:0]  waddr,
   input  logic [63:0] wdata,
   input  logic [4:0]  raddr,
   output logic [63:0] rdata
);
   logic [63:0] mem [32];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ----- rtl/c8_memory.sv -----
// Byte main memory of the CHIP-8 core, one write and one registered read.
// Uses c8_pkg.
module c8_memory import c8_pkg::*; (
   input  logic        clock,
   input  logic        we,
   input  logic [11:0] waddr,
   input  logic [7:0]  wdata,
   input  logic [11:0] raddr,
   output logic [7:0]  rdata
);
   logic [7:0] mem [4096];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

// ----- dv/tb_chip8_instruction_core_top.sv -----
// Self-checking testbench for chip8_instruction_core_top.
// It predicts every response beat from its own CHIP-8 machine model and checks it.
// Depends on c8_pkg and the core RTL; nothing else.
`timescale 1ns / 1ps
module tb_chip8_instruction_core_top;
   import c8_pkg::*;

   localparam logic [1:0]  KIND_NONE = 2'd3;
   localparam logic [3:0]  OP_SYS = 4'h0, OP_JP = 4'h1, OP_CALL = 4'h2, OP_SEI = 4'h3;
   localparam logic [3:0]  OP_SNEI = 4'h4, OP_SER = 4'h5, OP_LDI = 4'h6, OP_ADDI = 4'h7;
   localparam logic [3:0]  OP_ALU = 4'h8, OP_SNER = 4'h9, OP_LDX = 4'hA, OP_JPV = 4'hB;
   localparam logic [3:0]  OP_RND = 4'hC, OP_DRW = 4'hD, OP_KEY = 4'hE, OP_MISC = 4'hF;
   localparam logic [3:0]  ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
   localparam logic [3:0]  ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
   localparam logic [3:0]  ALU_SHL = 4'hE;
   localparam logic [11:0] SYS_CLS = 12'h0E0, SYS_RET = 12'h0EE;
   localparam logic [7:0]  MISC_ADDI = 8'h1E, MISC_STORE = 8'h55, MISC_LOAD = 8'h65;
   localparam logic [7:0]  MISC_TIMER = 8'h07, MISC_BCD = 8'h33;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = '0;
   logic [11:0] req_address = '0;
   logic [7:0]  req_write_byte = '0;
   logic [4:0]  req_row = '0;
   logic [7:0]  req_random_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_instruction;
   logic [11:0] rsp_pc;
   logic [15:0] rsp_index_value;
   logic [7:0]  rsp_flag_value;
   logic [63:0] rsp_row_bits;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [11:0] csr_data = '0;

   chip8_instruction_core_top dut (.*);

   always #5 clock = ~clock;

   // machine image
   logic [7:0]  mem_img [4096];
   logic [63:0] scr_img [32];
   logic [7:0]  vreg [16];
   logic [15:0] ireg;
   logic [11:0] pc_reg;
   logic [11:0] ret_stk [16];
   int          depth;
   logic [11:0] start_cfg;
   logic [4:0]  limit_cfg;

   rsp_type     expected_q [$];
   int          errors = 0;
   int          beats_sent = 0;
   bit          tx_quiet = 0;
   bit          rx_quiet = 0;
   int          hold_asks = 0;
   int          hold_seen = 0;

   function automatic logic [2:0] run_word(input logic [15:0] ins, input logic [7:0] rnd);
      logic [3:0]  x, y, n;
      logic [11:0] nnn, nxt, skp;
      logic [7:0]  nn, vx, vy;
      logic [8:0]  sum;
      logic [15:0] a;
      logic [63:0] bits;
      logic [2:0]  st;
      int          yy, lim;
      x = ins[11:8]; y = ins[7:4]; n = ins[3:0]; nnn = ins[11:0]; nn = ins[7:0];
      vx = vreg[x]; vy = vreg[y];
      nxt = pc_reg + 12'd2; skp = pc_reg + 12'd4;
      st = ST_OK;
      case (ins[15:12])
         OP_SYS: begin
            if (nnn == SYS_CLS) begin
               for (int r = 0; r < 32; r++) scr_img[r] = '0;
               pc_reg = nxt;
            end else if (nnn == SYS_RET) begin
               if (depth == 0) st = ST_EMPTY;
               else begin
                  depth--;
                  pc_reg = ret_stk[depth];
               end
            end else st = ST_UNSUP;
         end
         OP_JP: pc_reg = nnn;
         OP_CALL: begin
            lim = (limit_cfg > 16) ? 16 : limit_cfg;
            if (depth >= lim) st = ST_NEST;
            else begin
               ret_stk[depth] = nxt;
               depth++;
               pc_reg = nnn;
            end
         end
         OP_SEI:  pc_reg = (vx == nn) ? skp : nxt;
         OP_SNEI: pc_reg = (vx != nn) ? skp : nxt;
         OP_SER:  pc_reg = (vx == vy) ? skp : nxt;
         OP_SNER: pc_reg = (vx != vy) ? skp : nxt;
         OP_LDI: begin vreg[x] = nn; pc_reg = nxt; end
         OP_ADDI: begin vreg[x] = vx + nn; pc_reg = nxt; end
         OP_ALU: begin
            case (n)
               ALU_MOV: vreg[x] = vy;
               ALU_OR:  vreg[x] = vx | vy;
               ALU_AND: vreg[x] = vx & vy;
               ALU_XOR: vreg[x] = vx ^ vy;
               ALU_ADD: begin
                  sum = {1'b0, vx} + {1'b0, vy};
                  vreg[15] = {7'd0, sum[8]}; vreg[x] = sum[7:0];
               end
               ALU_SUB: begin vreg[15] = {7'd0, vx >= vy}; vreg[x] = vx - vy; end
               ALU_SHR: begin vreg[15] = {7'd0, vx[0]}; vreg[x] = vx >> 1; end
               ALU_SUBN: begin vreg[15] = {7'd0, vy >= vx}; vreg[x] = vy - vx; end
               ALU_SHL: begin vreg[15] = {7'd0, vx[7]}; vreg[x] = vx << 1; end
               default: ;
            endcase
            pc_reg = nxt;
         end
         OP_LDX: begin ireg = {4'd0, nnn}; pc_reg = nxt; end
         OP_JPV: pc_reg = nnn + {4'd0, vreg[0]};
         OP_RND: begin vreg[x] = rnd & nn; pc_reg = nxt; end
         OP_DRW: begin
            vreg[15] = '0;
            for (int r = 0; r < n; r++) begin
               yy = vy[4:0] + r;
               if (yy >= 32) break;
               a = ireg + r[15:0];
               bits = {mem_img[a[11:0]], 56'd0} >> vx[5:0];
               if (|(scr_img[yy] & bits)) vreg[15] = 8'd1;
               scr_img[yy] ^= bits;
            end
            pc_reg = nxt;
         end
         OP_KEY: st = ST_UNSUP;
         default: begin
            if (nn == MISC_ADDI) ireg = ireg + {8'd0, vx};
            else if (nn == MISC_STORE) begin
               for (int i = 0; i <= x; i++) begin
                  a = ireg + i[15:0];
                  mem_img[a[11:0]] = vreg[i];
               end
            end else if (nn == MISC_LOAD) begin
               for (int i = 0; i <= x; i++) begin
                  a = ireg + i[15:0];
                  vreg[i] = mem_img[a[11:0]];
               end
            end else st = ST_UNSUP;
            if (st == ST_OK) pc_reg = nxt;
         end
      endcase
      return st;
   endfunction

   task automatic predict_beat(input logic [1:0] kind, input logic [11:0] addr,
                               input logic [7:0] wb, input logic [4:0] row,
                               input logic [7:0] rnd);
      rsp_type e;
      e = '0;
      e.status = ST_ACCESS;
      case (kind)
         KIND_WRITE: mem_img[addr] = wb;
         KIND_EXEC: begin
            e.instruction = {mem_img[pc_reg], mem_img[pc_reg + 12'd1]};
            e.status = run_word(e.instruction, rnd);
         end
         KIND_ROW: e.row_bits = scr_img[row];
         default: ;
      endcase
      e.pc = pc_reg;
      e.index_value = ireg;
      e.flag_value = vreg[15];
      expected_q.push_back(e);
   endtask

   function automatic int pick_gap();
      int r;
      if (tx_quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   task automatic send_beat(input logic [1:0] kind, input logic [11:0] addr,
                            input logic [7:0] wb, input logic [4:0] row,
                            input logic [7:0] rnd);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_address <= addr;
      req_write_byte <= wb;
      req_row <= row;
      req_random_byte <= rnd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(kind, addr, wb, row, rnd);
      beats_sent++;
   endtask

   task automatic tx_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic mem_write(input logic [11:0] addr, input logic [7:0] wb);
      send_beat(KIND_WRITE, addr, wb, 5'($urandom), 8'($urandom));
   endtask

   task automatic row_read(input logic [4:0] row);
      send_beat(KIND_ROW, 12'($urandom), 8'($urandom), row, 8'($urandom));
   endtask

   task automatic exec_here(input logic [7:0] rnd);
      send_beat(KIND_EXEC, 12'($urandom), 8'($urandom), 5'($urandom), rnd);
   endtask

   // place the word at PC, then run it
   task automatic run_ins(input logic [15:0] ins, input logic [7:0] rnd = 8'($urandom));
      logic [11:0] p;
      p = pc_reg;
      mem_write(p, ins[15:8]);
      mem_write(p + 12'd1, ins[7:0]);
      exec_here(rnd);
   endtask

   task automatic csr_put(input logic idx, input logic [11:0] data);
      tx_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_START) begin
         start_cfg = data;
         pc_reg = data;
      end else limit_cfg = data[4:0];
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response beat", 64'(rsp_status), 64'd0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_instruction !== e.instruction)
               report_mismatch("instruction", rsp_instruction, e.instruction);
            if (rsp_pc !== e.pc) report_mismatch("pc", rsp_pc, e.pc);
            if (rsp_index_value !== e.index_value)
               report_mismatch("index", rsp_index_value, e.index_value);
            if (rsp_flag_value !== e.flag_value)
               report_mismatch("vf", rsp_flag_value, e.flag_value);
            if (rsp_row_bits !== e.row_bits) report_mismatch("row", rsp_row_bits, e.row_bits);
         end
      end
   end

   // response stall: random runs, plus long holds on request
   int stall_left = 0;
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         stall_left = 300;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if (rx_quiet) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 3);
      end else rsp_stall <= 1'b0;
   end

   function automatic logic [15:0] random_word();
      logic [15:0] w;
      int r;
      w = 16'($urandom);
      case (w[15:12])
         OP_SYS: begin
            r = $urandom_range(0, 9);
            if (r < 4) w[11:0] = SYS_CLS;
            else if (r < 8) w[11:0] = SYS_RET;
         end
         OP_SEI, OP_SNEI: if ($urandom_range(0, 1)) w[7:0] = vreg[w[11:8]];
         OP_SER, OP_SNER: if ($urandom_range(0, 1)) w[7:4] = w[11:8];
         OP_ALU: if ($urandom_range(0, 3) != 0) w[3:0] = 4'($urandom_range(0, 7));
         OP_KEY: if ($urandom_range(0, 2) != 0) w[15:12] = OP_DRW;
         OP_MISC: begin
            r = $urandom_range(0, 9);
            if (r < 3) w[7:0] = MISC_ADDI;
            else if (r < 6) w[7:0] = MISC_STORE;
            else if (r < 9) w[7:0] = MISC_LOAD;
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic random_beats(input int count);
      int r, stop;
      stop = beats_sent + count;
      while (beats_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 70) run_ins(random_word());
         else if (r < 82) row_read(5'($urandom));
         else if (r < 92) mem_write(12'($urandom), 8'($urandom));
         else if (r < 97) exec_here(8'($urandom));
         else send_beat(KIND_NONE, 12'($urandom), 8'($urandom), 5'($urandom), 8'($urandom));
      end
   endtask

   task automatic test_directed();
      run_ins(16'h00E0);
      run_ins({OP_LDI, 4'h0, 8'hFF});
      run_ins({OP_LDI, 4'h1, 8'h01});
      for (int k = 0; k < 16; k++) run_ins({OP_ALU, 4'h2, 4'h1, 4'(k)});
      run_ins({OP_ALU, 4'hF, 4'h0, ALU_ADD});
      run_ins({OP_ALU, 4'hF, 4'h0, ALU_SHL});
      run_ins({OP_ADDI, 4'h3, 8'hFF});
      run_ins({OP_SEI, 4'h0, 8'hFF});
      run_ins({OP_SNEI, 4'h0, 8'hFF});
      run_ins({OP_SER, 4'h0, 4'h0, 4'h7});
      run_ins({OP_SNER, 4'h0, 4'h1, 4'h0});
      run_ins({OP_LDX, 12'hFFE});
      run_ins({OP_MISC, 4'hF, MISC_STORE});
      run_ins({OP_MISC, 4'h3, MISC_LOAD});
      run_ins({OP_MISC, 4'h0, MISC_ADDI});
      run_ins({OP_LDI, 4'h4, 8'd60});
      run_ins({OP_LDI, 4'h5, 8'd30});
      run_ins({OP_DRW, 4'h4, 4'h5, 4'hF});
      run_ins({OP_DRW, 4'h4, 4'h5, 4'hF});
      row_read(5'd30);
      row_read(5'd31);
      run_ins({OP_RND, 4'h6, 8'hFF}, 8'hA5);
      run_ins({OP_SYS, SYS_RET});
      run_ins({OP_CALL, 12'h300});
      run_ins({OP_SYS, SYS_RET});
      run_ins({OP_JPV, 12'hFFF});
      run_ins({OP_JP, 12'h200});
      run_ins(16'h0123);
      run_ins(16'hE09E);
      run_ins({OP_MISC, 4'h1, MISC_TIMER});
      run_ins({OP_MISC, 4'h1, MISC_BCD});
      send_beat(KIND_NONE, 12'hFFF, 8'hFF, 5'd31, 8'hFF);
   endtask

   task automatic test_call_limits();
      csr_put(CSR_LIMIT, 12'd1);
      for (int k = 0; k < 3; k++) run_ins({OP_CALL, 12'($urandom)});
      for (int k = 0; k < 2; k++) run_ins({OP_SYS, SYS_RET});
      csr_put(CSR_LIMIT, 12'd16);
      for (int k = 0; k < 18; k++) run_ins({OP_CALL, 12'($urandom)});
      for (int k = 0; k < 17; k++) run_ins({OP_SYS, SYS_RET});
   endtask

   task automatic test_start_extremes();
      csr_put(CSR_START, 12'hFFF);
      run_ins({OP_LDI, 4'hA, 8'h5A});
      random_beats(60);
      csr_put(CSR_START, 12'h000);
      random_beats(60);
   endtask

   task automatic test_backpressure();
      tx_quiet = 1;
      hold_asks++;
      random_beats(40);
      tx_quiet = 0;
   endtask

   task automatic test_random();
      random_beats(400);
      tx_quiet = 1; rx_quiet = 1;
      random_beats(150);
      tx_quiet = 0; rx_quiet = 0;
      csr_put(CSR_LIMIT, 12'd5);
      csr_put(CSR_START, 12'h200);
      random_beats(400);
   endtask

   initial begin
      for (int k = 0; k < 4096; k++) mem_img[k] = '0;
      for (int k = 0; k < 32; k++) scr_img[k] = '0;
      for (int k = 0; k < 16; k++) begin vreg[k] = '0; ret_stk[k] = '0; end
      ireg = '0; depth = 0;
      start_cfg = RESET_START; limit_cfg = RESET_LIMIT; pc_reg = RESET_START;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_call_limits();
      test_start_extremes();
      test_backpressure();
      test_random();
      tx_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
